FILE: rtl/cdc_pkg.sv
// ----------------------------------------------------------------------------
// cdc_pkg: shared types and constants of the charge dose controller
// Mode codes, command codes, target ranges, fixed-point scaling and the
// widths of the sample sum and of the ppm divider.
// ----------------------------------------------------------------------------
package cdc_pkg;

  // Converter and update rate
  localparam int unsigned AdcBits          = 10;
  localparam int unsigned SamplesPerUpdate = 6;
  localparam int unsigned FracBits         = 16;

  // Field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned SmpW   = 10;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned PpmW   = 7;
  localparam int unsigned MlW    = 10;
  localparam int unsigned TotalW = 32;
  localparam int unsigned MinW   = 16;
  localparam int unsigned IdxW   = 3;

  // Stream data widths (whole bytes)
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 72;

  // Sum of calibrated samples and the increment divider
  localparam int unsigned SumW   = 14;
  localparam int unsigned MagW   = SumW;
  localparam int unsigned Scale  = 50 * (2 ** (FracBits - AdcBits));
  localparam int unsigned ScaleW = $clog2(Scale + 1);
  localparam int unsigned NumW   = MagW + ScaleW;
  localparam int unsigned DenW   = 14;
  localparam int unsigned CntW   = $clog2(NumW);
  localparam int unsigned AccW   = TotalW + 1;

  // Targets
  localparam logic [PpmW-1:0] PpmMin  = PpmW'(5);
  localparam logic [PpmW-1:0] PpmMax  = PpmW'(100);
  localparam logic [PpmW-1:0] PpmStep = PpmW'(5);
  localparam logic [MlW-1:0]  MlMin   = MlW'(50);
  localparam logic [MlW-1:0]  MlMax   = MlW'(1000);
  localparam logic [MlW-1:0]  MlStep  = MlW'(50);
  localparam logic [MinW-1:0] MinMax  = '1;

  // Modes
  localparam logic [ModeW-1:0] ModeSetPpm   = 3'd0;
  localparam logic [ModeW-1:0] ModeSetMl    = 3'd1;
  localparam logic [ModeW-1:0] ModeAskStart = 3'd2;
  localparam logic [ModeW-1:0] ModeRunning  = 3'd3;
  localparam logic [ModeW-1:0] ModeFinished = 3'd4;

  // Commands
  localparam logic [CmdW-1:0] CmdChange = 2'd0;
  localparam logic [CmdW-1:0] CmdNext   = 2'd1;
  localparam logic [CmdW-1:0] CmdSample = 2'd2;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_ACC  = 6'b001000,
    ST_CHK  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

endpackage

FILE: rtl/charge_dose_controller.sv
// ----------------------------------------------------------------------------
// charge_dose_controller: electrolysis dose controller
// Button levels set the ppm and volume targets and step the mode; samples
// taken while running are summed and turned into a fixed-point ppm total.
// ----------------------------------------------------------------------------
// Every accepted beat gives exactly one result beat holding the whole state.
// A button beat, a sample that does not close an update, an ignored sample or
// an unused command passes through the output state before the result is loaded.
// The sample that closes an update (every sixth sample while running) passes
// through the prepare, divide, accumulate, check and output states: the ppm
// increment comes from a restoring divider that resolves one quotient bit a cycle
// over a 26-bit numerator, followed by a saturating add and the target compare.
// The input is not ready while an item is being worked on; a finished result
// waits in the output register while the next beat is accepted.
module charge_dose_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: calibration counts
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [0] button_level, [10:1] sample_counts
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // [2:0] mode_now, [9:3] target_ppm,
                                     // [19:10] target_ml, [51:20] ppm_reached,
                                     // [67:52] minutes_run, [68] power_on
);

  cdc_pkg::state_e state_q, state_d;

  logic [cdc_pkg::SmpW-1:0]   cal_q;
  logic [cdc_pkg::ModeW-1:0]  mode_q, mode_d;
  logic [cdc_pkg::PpmW-1:0]   ppm_goal_q, ppm_goal_d;
  logic [cdc_pkg::MlW-1:0]    ml_goal_q, ml_goal_d;
  logic                       chg_lvl_q, chg_lvl_d;
  logic                       nxt_lvl_q, nxt_lvl_d;
  logic [cdc_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [cdc_pkg::SumW-1:0]   sum_q, sum_d;
  logic [cdc_pkg::TotalW-1:0] total_q, total_d;
  logic [cdc_pkg::MinW-1:0]   minutes_q, minutes_d;
  logic                       drive_q, drive_d;

  // Divider
  logic                       neg_q, neg_d;
  logic [cdc_pkg::NumW-1:0]   num_q, num_d;
  logic [cdc_pkg::DenW-1:0]   den_q, den_d;
  logic [cdc_pkg::DenW-1:0]   rem_q, rem_d;
  logic [cdc_pkg::CntW-1:0]   cnt_q, cnt_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic [cdc_pkg::OutDataW-1:0] out_data_q, out_data_d;

  // Input fields
  logic [cdc_pkg::CmdW-1:0] cmd;
  logic                     lvl;
  logic [cdc_pkg::SmpW-1:0] smp;

  // Datapath helpers
  logic                       accept;
  logic [cdc_pkg::SumW-1:0]   sum_new;
  logic [cdc_pkg::IdxW-1:0]   idx_new;
  logic [cdc_pkg::MagW-1:0]   mag;
  logic [cdc_pkg::DenW:0]     rem_shift;
  logic [cdc_pkg::DenW:0]     rem_sub;
  logic [cdc_pkg::NumW:0]     inc;
  logic [cdc_pkg::AccW-1:0]   acc;
  logic [cdc_pkg::TotalW-1:0] goal_fix;

  assign cmd = s_axis_tuser;
  assign lvl = s_axis_tdata[0];
  assign smp = s_axis_tdata[cdc_pkg::SmpW:1];

  assign s_axis_tready = (state_q == cdc_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Sample sum and position within the update
  assign sum_new = sum_q + cdc_pkg::SumW'(smp) - cdc_pkg::SumW'(cal_q);
  assign idx_new = idx_q + cdc_pkg::IdxW'(1);

  // Magnitude of the sum, rounding of the increment is toward zero
  assign mag = sum_q[cdc_pkg::SumW-1] ? (~sum_q + cdc_pkg::SumW'(1)) : sum_q;

  // One restoring step: shift in the next numerator bit, trial subtract
  assign rem_shift = {rem_q, num_q[cdc_pkg::NumW-1]};
  assign rem_sub   = rem_shift - {1'b0, den_q};

  // Signed increment and saturating total
  assign inc = neg_q ? (~{1'b0, num_q} + (cdc_pkg::NumW+1)'(1)) : {1'b0, num_q};
  assign acc = {total_q[cdc_pkg::TotalW-1], total_q}
             + {{(cdc_pkg::AccW-cdc_pkg::NumW-1){inc[cdc_pkg::NumW]}}, inc};
  assign goal_fix = cdc_pkg::TotalW'({ppm_goal_q, {cdc_pkg::FracBits{1'b0}}});

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    ppm_goal_d  = ppm_goal_q;
    ml_goal_d   = ml_goal_q;
    chg_lvl_d   = chg_lvl_q;
    nxt_lvl_d   = nxt_lvl_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    total_d     = total_q;
    minutes_d   = minutes_q;
    drive_d     = drive_q;
    neg_d       = neg_q;
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    case (state_q)
      cdc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = cdc_pkg::ST_OUT;
          case (cmd)
            cdc_pkg::CmdChange: begin
              if (mode_q < cdc_pkg::ModeAskStart && lvl != chg_lvl_q) begin
                chg_lvl_d = lvl;
                if (lvl) begin
                  if (mode_q == cdc_pkg::ModeSetPpm) begin
                    ppm_goal_d = (ppm_goal_q < cdc_pkg::PpmMax) ?
                                 ppm_goal_q + cdc_pkg::PpmStep : cdc_pkg::PpmMin;
                  end else begin
                    ml_goal_d = (ml_goal_q < cdc_pkg::MlMax) ?
                                ml_goal_q + cdc_pkg::MlStep : cdc_pkg::MlMin;
                  end
                end
              end
            end
            cdc_pkg::CmdNext: begin
              if (mode_q < cdc_pkg::ModeRunning && lvl != nxt_lvl_q) begin
                nxt_lvl_d = lvl;
                if (lvl) begin
                  mode_d = mode_q + cdc_pkg::ModeW'(1);
                  if (mode_q == cdc_pkg::ModeAskStart) begin
                    drive_d = 1'b1;
                  end
                end
              end
            end
            cdc_pkg::CmdSample: begin
              if (mode_q == cdc_pkg::ModeRunning) begin
                sum_d = sum_new;
                idx_d = idx_new;
                if (idx_new == cdc_pkg::IdxW'(cdc_pkg::SamplesPerUpdate)) begin
                  state_d = cdc_pkg::ST_PREP;
                end
              end
            end
            default: begin
              // unused command: state reported unchanged
            end
          endcase
        end
      end

      // Load the divider, close the update window, count the minute
      cdc_pkg::ST_PREP: begin
        neg_d = sum_q[cdc_pkg::SumW-1];
        num_d = cdc_pkg::NumW'(mag) * cdc_pkg::NumW'(cdc_pkg::Scale);
        den_d = cdc_pkg::DenW'({ml_goal_q, 3'b000}) + cdc_pkg::DenW'(ml_goal_q);
        rem_d = '0;
        cnt_d = '0;
        sum_d = '0;
        idx_d = '0;
        if (minutes_q != cdc_pkg::MinMax) begin
          minutes_d = minutes_q + cdc_pkg::MinW'(1);
        end
        state_d = cdc_pkg::ST_DIV;
      end

      // One quotient bit a cycle; the numerator register fills with quotient
      cdc_pkg::ST_DIV: begin
        if (!rem_sub[cdc_pkg::DenW]) begin
          rem_d = rem_sub[cdc_pkg::DenW-1:0];
          num_d = {num_q[cdc_pkg::NumW-2:0], 1'b1};
        end else begin
          rem_d = rem_shift[cdc_pkg::DenW-1:0];
          num_d = {num_q[cdc_pkg::NumW-2:0], 1'b0};
        end
        cnt_d = cnt_q + cdc_pkg::CntW'(1);
        if (cnt_q == cdc_pkg::CntW'(cdc_pkg::NumW - 1)) begin
          state_d = cdc_pkg::ST_ACC;
        end
      end

      // Saturating add of the increment
      cdc_pkg::ST_ACC: begin
        if (acc[cdc_pkg::AccW-1] != acc[cdc_pkg::AccW-2]) begin
          total_d = acc[cdc_pkg::AccW-1] ? {1'b1, {(cdc_pkg::TotalW-1){1'b0}}}
                                         : {1'b0, {(cdc_pkg::TotalW-1){1'b1}}};
        end else begin
          total_d = acc[cdc_pkg::TotalW-1:0];
        end
        state_d = cdc_pkg::ST_CHK;
      end

      // Target reached: power off, finished
      cdc_pkg::ST_CHK: begin
        if ($signed(total_q) >= $signed(goal_fix)) begin
          drive_d = 1'b0;
          mode_d  = cdc_pkg::ModeFinished;
        end
        state_d = cdc_pkg::ST_OUT;
      end

      // Hand the state to the output register once it is free
      cdc_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, drive_q, minutes_q, total_q,
                         ml_goal_q, ppm_goal_q, mode_q};
          state_d     = cdc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cdc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdc_pkg::ST_IDLE;
      cal_q       <= '0;
      mode_q      <= cdc_pkg::ModeSetPpm;
      ppm_goal_q  <= cdc_pkg::PpmMin;
      ml_goal_q   <= cdc_pkg::MlMin;
      chg_lvl_q   <= 1'b0;
      nxt_lvl_q   <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
      total_q     <= '0;
      minutes_q   <= '0;
      drive_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cal_q <= cfg_wdata_i;
      end
      mode_q      <= mode_d;
      ppm_goal_q  <= ppm_goal_d;
      ml_goal_q   <= ml_goal_d;
      chg_lvl_q   <= chg_lvl_d;
      nxt_lvl_q   <= nxt_lvl_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      total_q     <= total_d;
      minutes_q   <= minutes_d;
      drive_q     <= drive_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Divider and output payload
  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    num_q      <= num_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
    out_data_q <= out_data_d;
  end

  // Power is driven only in the running mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q |-> (mode_q == cdc_pkg::ModeRunning))
    else $error("power on outside running mode");

  // Sample position never reaches the update length between beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cdc_pkg::ST_IDLE) |-> (idx_q < cdc_pkg::IdxW'(cdc_pkg::SamplesPerUpdate)))
    else $error("sample index past update length");

  // Divider remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cdc_pkg::ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder out of range");

  // Targets stay inside their ranges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ppm_goal_q >= cdc_pkg::PpmMin) && (ppm_goal_q <= cdc_pkg::PpmMax) &&
    (ml_goal_q >= cdc_pkg::MlMin) && (ml_goal_q <= cdc_pkg::MlMax))
    else $error("target out of range");

  // A result is loaded on leaving the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cdc_pkg::ST_OUT) && (state_d == cdc_pkg::ST_IDLE) |=> m_axis_tvalid)
    else $error("result not presented");

endmodule

FILE: bench/charge_dose_controller_test.sv
// ----------------------------------------------------------------------------
// charge_dose_controller_test: self-checking bench for the dose controller
// Drives button, sample and unused beats through the input stream, tracks
// modes, targets, sample sums and the fixed-point ppm total in a scoreboard
// and checks every result beat field by field against that state.
// ----------------------------------------------------------------------------
module charge_dose_controller_test;
  import cdc_pkg::*;

  // Bench constants
  localparam logic [CmdW-1:0] CmdUnused    = 2'd3;
  localparam logic [PpmW-1:0] RunPpm       = PpmW'(15);
  localparam logic [MlW-1:0]  RunMl        = MlW'(50);
  localparam int              SettleCycles = 40;
  localparam int              HoldCycles   = 300;
  localparam int              StallLimit   = 3000;
  localparam longint          TotalMax     = 64'sd2147483647;
  localparam longint          TotalMin     = -64'sd2147483648;

  // One expected result beat
  typedef struct {
    logic [ModeW-1:0]  mode;
    logic [PpmW-1:0]   ppm;
    logic [MlW-1:0]    ml;
    logic [TotalW-1:0] reached;
    logic [MinW-1:0]   minutes;
    logic              power;
  } dose_status_t;

  // Dose state tracker and result checker
  class dose_scoreboard;
    logic [ModeW-1:0] mode         = ModeSetPpm;
    logic [PpmW-1:0]  ppm_goal     = PpmMin;
    logic [MlW-1:0]   ml_goal      = MlMin;
    logic             change_level = 1'b0;
    logic             next_level   = 1'b0;
    logic [IdxW-1:0]  sample_idx   = '0;
    int               count_sum    = 0;
    int               ppm_total    = 0;
    logic [MinW-1:0]  minutes      = '0;
    logic             drive        = 1'b0;
    logic [SmpW-1:0]  calibration  = '0;
    dose_status_t     status_q[$];
    int               mismatches   = 0;
    int               checked      = 0;
    int               updates      = 0;

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH: %s", what);
    endtask

    // Sixth sample: fold the sum into the ppm total, count a minute
    function void close_update();
      longint mag;
      longint quot;
      longint acc;
      mag  = (count_sum < 0) ? -longint'(count_sum) : longint'(count_sum);
      quot = (mag * 50 * (longint'(1) << (FracBits - AdcBits))) / (9 * longint'(ml_goal));
      if (quot > TotalMax) quot = TotalMax;
      acc = longint'(ppm_total) + ((count_sum < 0) ? -quot : quot);
      if (acc > TotalMax) acc = TotalMax;
      if (acc < TotalMin) acc = TotalMin;
      ppm_total = int'(acc);
      if (minutes != MinMax) minutes++;
      sample_idx = '0;
      count_sum  = 0;
      updates++;
      if (longint'(ppm_total) >= longint'(ppm_goal) * 65536) begin
        drive = 1'b0;
        mode  = ModeFinished;
      end
    endfunction

    // Accepted input beat: update state, queue the status it yields
    function void note_beat(logic [CmdW-1:0] cmd, logic level, logic [SmpW-1:0] smp);
      dose_status_t s;
      case (cmd)
        CmdChange: begin
          if (mode < ModeAskStart && level != change_level) begin
            change_level = level;
            if (level) begin
              if (mode == ModeSetPpm) ppm_goal = (ppm_goal < PpmMax) ? ppm_goal + PpmStep : PpmMin;
              else ml_goal = (ml_goal < MlMax) ? ml_goal + MlStep : MlMin;
            end
          end
        end
        CmdNext: begin
          if (mode < ModeRunning && level != next_level) begin
            next_level = level;
            if (level) begin
              mode = mode + 1'b1;
              if (mode == ModeRunning) drive = 1'b1;
            end
          end
        end
        CmdSample: begin
          if (mode == ModeRunning) begin
            count_sum += int'(smp) - int'(calibration);
            sample_idx = sample_idx + 1'b1;
            if (sample_idx == IdxW'(SamplesPerUpdate)) close_update();
          end
        end
        default: ;
      endcase
      s.mode    = mode;
      s.ppm     = ppm_goal;
      s.ml      = ml_goal;
      s.reached = ppm_total;
      s.minutes = minutes;
      s.power   = drive;
      status_q.push_back(s);
    endfunction

    // Result beat against the oldest expectation
    task check_result(logic [OutDataW-1:0] d);
      dose_status_t want;
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: %h", d));
        return;
      end
      want = status_q.pop_front();
      checked++;
      if (d[2:0] != want.mode)
        report_mismatch($sformatf("beat %0d mode_now %0d, want %0d", checked, d[2:0], want.mode));
      if (d[9:3] != want.ppm)
        report_mismatch($sformatf("beat %0d target_ppm %0d, want %0d", checked, d[9:3], want.ppm));
      if (d[19:10] != want.ml)
        report_mismatch($sformatf("beat %0d target_ml %0d, want %0d", checked, d[19:10], want.ml));
      if (d[51:20] != want.reached)
        report_mismatch($sformatf("beat %0d ppm_reached %h, want %h", checked, d[51:20],
                                  want.reached));
      if (d[67:52] != want.minutes)
        report_mismatch($sformatf("beat %0d minutes_run %0d, want %0d", checked, d[67:52],
                                  want.minutes));
      if (d[68] != want.power)
        report_mismatch($sformatf("beat %0d power_on %0b, want %0b", checked, d[68], want.power));
    endtask
  endclass

  // Clock, reset and block ports
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [SmpW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // [0] button_level, [10:1] sample_counts
  logic [CmdW-1:0]     s_axis_tuser  = '0;  // [1:0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [2:0] mode, [9:3] ppm, [19:10] ml,
                                            // [51:20] ppm_reached, [67:52] minutes,
                                            // [68] power_on

  dose_scoreboard dose_sb = new();

  int   items_sent     = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;
  logic hold_req       = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  charge_dose_controller i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Result side: check beats, random stalls and the long hold-off
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) dose_sb.check_result(m_axis_tdata);
    if (hold_req && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any beat on either side
  initial begin : watchdog
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [SmpW-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return SmpW'($urandom_range(0, 1023));
  endfunction

  // One input beat; idling pattern rotates every 97 beats
  task automatic send_beat(logic [CmdW-1:0] cmd, logic level, logic [SmpW-1:0] smp);
    case ((items_sent / 97) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, smp, level};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    dose_sb.note_beat(cmd, level, smp);
    items_sent++;
  endtask

  // Let every result drain, then give the divider time to go quiet
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (dose_sb.status_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_calibration(logic [SmpW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dose_sb.calibration = value;
  endtask

  // Release then press, so the level always rises
  task automatic press_button(logic [CmdW-1:0] cmd);
    logic held;
    held = (cmd == CmdChange) ? dose_sb.change_level : dose_sb.next_level;
    if (held) send_beat(cmd, 1'b0, rand_sample());
    send_beat(cmd, 1'b1, rand_sample());
  endtask

  // Setting modes: mostly change-button toggles, next button kept low
  task automatic setup_phase(int n);
    int   pick;
    logic level;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        level = ($urandom_range(0, 9) < 7) ? !dose_sb.change_level : dose_sb.change_level;
        send_beat(CmdChange, level, rand_sample());
      end else if (pick < 75) begin
        send_beat(CmdNext, 1'b0, rand_sample());
      end else if (pick < 90) begin
        send_beat(CmdSample, 1'($urandom_range(0, 1)), rand_sample());
      end else begin
        send_beat(CmdUnused, 1'($urandom_range(0, 1)), rand_sample());
      end
    end
  endtask

  // Running: mostly samples, some stray button and unused beats; the long
  // result hold-off starts together with the beats of this phase
  task automatic run_phase(logic [SmpW-1:0] cal, int n, logic hold);
    settle_block();
    write_calibration(cal);
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < n && dose_sb.mode == ModeRunning; i++) begin
      if ($urandom_range(0, 99) < 90)
        send_beat(CmdSample, 1'($urandom_range(0, 1)), rand_sample());
      else
        send_beat(CmdW'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_sample());
    end
  endtask

  // Main sequence
  initial begin : stimulus
    int unsigned cal_plan[6];
    int          len_plan[6];
    cal_plan = '{0, 1023, 128, 0, 0, 64};
    len_plan = '{150, 60, 150, 120, 150, 150};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_calibration(SmpW'($urandom_range(0, 1023)));

    // Directed: ignored beats, held levels, target stepping
    send_beat(CmdSample, 1'b1, '1);
    send_beat(CmdUnused, 1'b1, '1);
    send_beat(CmdNext, 1'b0, '0);
    send_beat(CmdChange, 1'b1, '0);
    send_beat(CmdChange, 1'b1, '1);
    send_beat(CmdChange, 1'b0, 10'h2AA);
    send_beat(CmdChange, 1'b1, 10'h155);
    send_beat(CmdUnused, 1'b0, '0);
    send_beat(CmdSample, 1'b0, '0);

    // ppm target: random toggling (wraps), then steer to the run target
    setup_phase(150);
    while (dose_sb.ppm_goal != RunPpm) press_button(CmdChange);
    press_button(CmdNext);

    // volume target likewise
    setup_phase(150);
    while (dose_sb.ml_goal != RunMl) press_button(CmdChange);
    press_button(CmdNext);

    // asking for start: change button ignored, level not tracked
    send_beat(CmdChange, !dose_sb.change_level, '1);
    send_beat(CmdSample, 1'b1, '1);
    setup_phase(25);
    press_button(CmdNext);
    send_beat(CmdNext, 1'b0, '0);
    send_beat(CmdNext, 1'b1, '1);

    // running under several calibration settings until the target is met
    for (int p = 0; p < 8 && dose_sb.mode == ModeRunning; p++) begin
      run_phase((p % 6 == 3) ? SmpW'($urandom_range(0, 1023)) : SmpW'(cal_plan[p % 6]),
                len_plan[p % 6], (p == 1));
    end

    // finished (or still running): anything goes
    for (int i = 0; i < 30; i++)
      send_beat(CmdW'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_sample());

    settle_block();
    if (dose_sb.status_q.size() != 0)
      dose_sb.report_mismatch($sformatf("%0d results never arrived", dose_sb.status_q.size()));
    $display("Run: %0d input beats, %0d result beats checked, %0d ppm updates, %0d mismatches",
             items_sent, dose_sb.checked, dose_sb.updates, dose_sb.mismatches);
    $display("Final mode %0d, ppm total %h, minutes %0d, ppm target %0d, volume %0d ml",
             dose_sb.mode, dose_sb.ppm_total, dose_sb.minutes, dose_sb.ppm_goal,
             dose_sb.ml_goal);
    if (dose_sb.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
